// ===== rtl/scfr_pkg.sv =====
package scfr_pkg;

    // Default sizing of the frame buffer and of the delivered payload
    localparam int BUFFER_BYTES_DEF   = 32;
    localparam int FRAME_DATA_MAX_DEF = 28;

    // Bytes of a buffer not available to the body (head, length, checksum)
    localparam int LEN_OVERHEAD = 3;

    // Width of a queued payload length; holds any length the parameters allow
    localparam int JOB_LEN_W = 8;

    typedef enum logic [1:0] {
        ST_BYTE = 2'd0,
        ST_DROP = 2'd1,
        ST_CHK  = 2'd2,
        ST_LEN  = 2'd3
    } status_t;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_RELEASE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] command;
        logic [4:0] payload_len;
        logic [7:0] data_byte;
        logic [4:0] byte_index;
        logic       has_data;
        logic       last;
        logic       linked;
    } out_t;

    // Work handed from the parser to the result sequencer
    typedef struct packed {
        status_t                status;
        logic [7:0]             command;
        logic [JOB_LEN_W-1:0]   payload_len;
        logic                   linked;
    } job_t;

endpackage

// ===== rtl/scfr_queue.sv =====
module scfr_queue
    import scfr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head_job
);

    // Two-entry job FIFO
    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/scfr_front.sv =====
module scfr_front
    import scfr_pkg::*;
#(
    parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
    parameter int FRAME_DATA_MAX = FRAME_DATA_MAX_DEF,
    localparam int CNT_W         = $clog2(BUFFER_BYTES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             push,
    output job_t             push_job,
    input  logic             q_full,
    input  logic             frame_done,
    output logic             st_wr_en,
    output logic [CNT_W-1:0] st_wr_addr,
    output logic [7:0]       st_wr_data
);

    localparam logic [7:0] LEN_LIMIT = 8'(BUFFER_BYTES - LEN_OVERHEAD);
    localparam logic [JOB_LEN_W-1:0] DATA_MAX = JOB_LEN_W'(FRAME_DATA_MAX);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_CHK
    } phase_t;

    phase_t             phase_reg;
    logic [7:0]         head_byte_reg;
    logic [CNT_W-1:0]   body_count_reg;
    logic [CNT_W-1:0]   body_len_reg;
    logic [7:0]         running_sum_reg;
    logic [7:0]         command_reg;
    logic               frame_pending_reg;
    logic               link_up_reg;
    logic               frame_out_reg;

    logic               take;
    logic               is_byte;
    logic [7:0]         b;
    logic [7:0]         sum_next;
    logic [JOB_LEN_W-1:0] body_less;
    logic [JOB_LEN_W-1:0] plen;
    logic [CNT_W:0]     count_next;

    // Body bytes wait while an accepted frame is still being read out of the store
    assign s_ready = !q_full && !((phase_reg == PH_BODY) && frame_out_reg);
    assign take    = s_valid && s_ready;
    assign is_byte = (s_data.opcode == OP_BYTE);
    assign b       = s_data.rx_byte;

    assign sum_next   = running_sum_reg + b;
    assign body_less  = JOB_LEN_W'(body_len_reg) - JOB_LEN_W'(1);
    assign plen       = (body_less > DATA_MAX) ? DATA_MAX : body_less;
    assign count_next = {1'b0, body_count_reg} + {{CNT_W{1'b0}}, 1'b1};

    assign st_wr_en   = take && is_byte && (phase_reg == PH_BODY);
    assign st_wr_addr = body_count_reg;
    assign st_wr_data = b;

    always_comb begin
        push     = 1'b0;
        push_job = '{status: ST_LEN, command: 8'd0, payload_len: '0, linked: link_up_reg};
        if (take && is_byte) begin
            case (phase_reg)
                PH_LEN: begin
                    if ((b == 8'd0) || (b > LEN_LIMIT)) begin
                        push = 1'b1;
                    end
                end
                PH_CHK: begin
                    push = 1'b1;
                    if (sum_next != 8'd0) begin
                        push_job.status = ST_CHK;
                    end else if (frame_pending_reg) begin
                        push_job.status = ST_DROP;
                    end else begin
                        push_job.status      = ST_BYTE;
                        push_job.command     = command_reg;
                        push_job.payload_len = plen;
                        push_job.linked      = 1'b1;
                    end
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HUNT;
            head_byte_reg     <= 8'hFF;
            body_count_reg    <= '0;
            body_len_reg      <= '0;
            running_sum_reg   <= 8'd0;
            frame_pending_reg <= 1'b0;
            link_up_reg       <= 1'b0;
            frame_out_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                head_byte_reg <= cfg_wr_data;
            end
            if (frame_done && !(push && (push_job.status == ST_BYTE))) begin
                frame_out_reg <= 1'b0;
            end
            if (take && !is_byte) begin
                frame_pending_reg <= 1'b0;
            end else if (take) begin
                case (phase_reg)
                    PH_HUNT: begin
                        if (b == head_byte_reg) begin
                            phase_reg <= PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if ((b == 8'd0) || (b > LEN_LIMIT)) begin
                            phase_reg <= PH_HUNT;
                        end else begin
                            body_len_reg    <= CNT_W'(b);
                            running_sum_reg <= b;
                            body_count_reg  <= '0;
                            phase_reg       <= PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (body_count_reg == '0) begin
                            command_reg <= b;
                        end
                        body_count_reg  <= count_next[CNT_W-1:0];
                        running_sum_reg <= sum_next;
                        if (count_next >= {1'b0, body_len_reg}) begin
                            phase_reg <= PH_CHK;
                        end
                    end
                    default: begin
                        phase_reg <= PH_HUNT;
                        if ((sum_next == 8'd0) && !frame_pending_reg) begin
                            frame_pending_reg <= 1'b1;
                            link_up_reg       <= 1'b1;
                            frame_out_reg     <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/scfr_back.sv =====
module scfr_back
    import scfr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    localparam int CNT_W       = $clog2(BUFFER_BYTES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  job_t             q_head,
    output logic             pop,
    output logic             frame_done,
    input  logic             st_wr_en,
    input  logic [CNT_W-1:0] st_wr_addr,
    input  logic [7:0]       st_wr_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } state_t;

    logic [7:0]           store_mem [BUFFER_BYTES];
    logic [7:0]           rd_data_reg;

    state_t               state_reg;
    job_t                 job_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    logic                 out_free;
    logic                 rd_en;
    logic [CNT_W-1:0]     rd_addr;
    logic                 at_last;
    logic                 head_has_data;
    logic                 flag_load;
    logic                 emit_load;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = (state_reg == S_READ);
    // The command sits at the head of the store; payload starts one entry later
    assign rd_addr  = idx_reg + CNT_W'(1);
    assign at_last  = ((JOB_LEN_W'(idx_reg) + JOB_LEN_W'(1)) == job_reg.payload_len);

    assign head_has_data = (q_head.status == ST_BYTE) && (q_head.payload_len != '0);

    assign pop = (state_reg == S_IDLE) && q_not_empty && (out_free || head_has_data);

    // Single-result jobs load the output register straight from the queue head
    assign flag_load = pop && !head_has_data;
    assign emit_load = (state_reg == S_EMIT) && out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (st_wr_en) begin
            store_mem[st_wr_addr] <= st_wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            frame_done  <= 1'b0;
            idx_reg     <= '0;
        end else begin
            frame_done <= (flag_load && (q_head.status == ST_BYTE)) || (emit_load && at_last);
            if (flag_load || emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        job_reg <= q_head;
                        idx_reg <= '0;
                        if (head_has_data) begin
                            state_reg <= S_READ;
                        end else begin
                            m_data_reg.status      <= q_head.status;
                            m_data_reg.command     <= q_head.command;
                            m_data_reg.payload_len <= 5'd0;
                            m_data_reg.data_byte   <= 8'd0;
                            m_data_reg.byte_index  <= 5'd0;
                            m_data_reg.has_data    <= 1'b0;
                            m_data_reg.last        <= 1'b1;
                            m_data_reg.linked      <= q_head.linked;
                        end
                    end
                end
                S_READ: begin
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_data_reg.status      <= ST_BYTE;
                        m_data_reg.command     <= job_reg.command;
                        m_data_reg.payload_len <= 5'(job_reg.payload_len);
                        m_data_reg.data_byte   <= rd_data_reg;
                        m_data_reg.byte_index  <= 5'(idx_reg);
                        m_data_reg.has_data    <= 1'b1;
                        m_data_reg.last        <= at_last;
                        m_data_reg.linked      <= job_reg.linked;
                        if (at_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + CNT_W'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sum_check_frame_receiver.sv =====
// Frame receiver for a serial byte stream. Frames run head, length, command,
// payload, checksum; the head value is set through cfg_wr_en/cfg_wr_data
// (0xFF after reset) and length counts the command plus payload. The parser
// takes one transaction per cycle while the result queue has room: hunting,
// length and checksum bytes, and releases, enter every clock unless the queue
// is full. Each good frame is read back out of the body store one result at a
// time: the store's registered read port is addressed, then the output
// register is loaded once it is free; flag results load it from the queue head.
// While a frame drains, body bytes of the next frame hold at s_ready low, as
// they would overwrite the store; hunting and length bytes still flow. A good
// frame sets the pending flag and the link flag; a release transaction
// (opcode 1) clears pending and produces nothing. A good frame arriving while
// one is pending gives a single "dropped" result, and bad length or bad
// checksum each give a single flag result, all marked last, carrying the
// current link flag, with other fields zero. A head value inside a frame
// counts as data.
module sum_check_frame_receiver
    import scfr_pkg::*;
#(
    parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
    parameter int FRAME_DATA_MAX = FRAME_DATA_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // head byte register
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // received bytes and releases
    input  logic       s_valid,
    output logic       s_ready,
    input  in_t        s_data,
    // results
    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_data
);

    localparam int CNT_W = $clog2(BUFFER_BYTES);

    logic             push;
    job_t             push_job;
    logic             q_full;
    logic             q_not_empty;
    job_t             q_head;
    logic             pop;
    logic             frame_done;
    logic             st_wr_en;
    logic [CNT_W-1:0] st_wr_addr;
    logic [7:0]       st_wr_data;

    // Parser: track phase and checksum, fill the body store, classify frames
    scfr_front #(
        .BUFFER_BYTES   (BUFFER_BYTES),
        .FRAME_DATA_MAX (FRAME_DATA_MAX)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .push        (push),
        .push_job    (push_job),
        .q_full      (q_full),
        .frame_done  (frame_done),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data)
    );

    // Decouple the parser from the result side
    scfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_job  (q_head)
    );

    // Result sequencer: hold the body store, drain frames and flag results
    scfr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .frame_done  (frame_done),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== tb/sv/tb_sum_check_frame_receiver.sv =====
module tb_sum_check_frame_receiver;
    import scfr_pkg::*;

    // Longest length byte that still fits head, length and checksum in the buffer
    localparam int LEN_LIMIT     = BUFFER_BYTES_DEF - LEN_OVERHEAD;
    // Watchdog: worst case is roughly 300 transactions each draining 28 results
    // behind a stalling receiver; take that several times
    localparam int CYCLE_LIMIT   = 200000;
    // Quiet cycles granted to the parser and result queue before a register
    // write and before the final verdict
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 200;
    localparam int IDLE_PERCENT  = 19;

    typedef enum logic [1:0] {
        HUNT,
        LENGTH,
        BODY,
        CHECK
    } parse_phase_t;

    // Tracks the parser state and the results that each transaction makes due,
    // and checks what the block delivers against them in order.
    class frame_tracker;
        logic [7:0]   head;
        parse_phase_t phase;
        int unsigned  body_count;
        int unsigned  body_len;
        logic [7:0]   running_sum;
        logic [7:0]   body_store [BUFFER_BYTES_DEF];
        bit           frame_pending;
        bit           link_up;
        out_t         due_results[$];
        int           errors;

        function new();
            errors        = 0;
            head          = 8'hFF;
            phase         = HUNT;
            body_count    = 0;
            body_len      = 0;
            running_sum   = 8'h00;
            frame_pending = 1'b0;
            link_up       = 1'b0;
            foreach (body_store[i]) body_store[i] = 8'h00;
        endfunction

        function int unsigned outstanding();
            return due_results.size();
        endfunction

        function void push_flag(status_t code);
            out_t r;
            r        = '0;
            r.status = code;
            r.last   = 1'b1;
            r.linked = link_up;
            due_results.push_back(r);
        endfunction

        function void deliver_frame();
            out_t        r;
            int unsigned plen;
            plen = body_len - 1;
            if (plen > FRAME_DATA_MAX_DEF) plen = FRAME_DATA_MAX_DEF;
            r         = '0;
            r.status  = ST_BYTE;
            r.command = body_store[0];
            r.linked  = link_up;
            if (plen == 0) begin
                r.last = 1'b1;
                due_results.push_back(r);
            end else begin
                for (int unsigned i = 0; i < plen; i++) begin
                    r.payload_len = 5'(plen);
                    r.data_byte   = (i + 1 < BUFFER_BYTES_DEF) ? body_store[i + 1] : 8'h00;
                    r.byte_index  = 5'(i);
                    r.has_data    = 1'b1;
                    r.last        = (i + 1 == plen);
                    due_results.push_back(r);
                end
            end
        endfunction

        function void accept_item(in_t t);
            logic [7:0] b;
            b = t.rx_byte;
            if (t.opcode == OP_RELEASE) begin
                frame_pending = 1'b0;
            end else begin
                case (phase)
                    HUNT: begin
                        if (b == head) phase = LENGTH;
                    end
                    LENGTH: begin
                        if (b == 8'd0 || b > LEN_LIMIT) begin
                            phase = HUNT;
                            push_flag(ST_LEN);
                        end else begin
                            body_len    = b;
                            running_sum = b;
                            body_count  = 0;
                            phase       = BODY;
                        end
                    end
                    BODY: begin
                        if (body_count < BUFFER_BYTES_DEF) body_store[body_count] = b;
                        body_count++;
                        running_sum = running_sum + b;
                        if (body_count >= body_len) phase = CHECK;
                    end
                    default: begin
                        phase = HUNT;
                        if (8'(running_sum + b) != 8'h00) begin
                            push_flag(ST_CHK);
                        end else if (frame_pending) begin
                            push_flag(ST_DROP);
                        end else begin
                            frame_pending = 1'b1;
                            link_up       = 1'b1;
                            deliver_frame();
                        end
                    end
                endcase
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result %h arrived with nothing due, expected none, got %h",
                         $time, got, got);
            end else begin
                want = due_results.pop_front();
                compare_field("status",      want.status,      got.status);
                compare_field("command",     want.command,     got.command);
                compare_field("payload_len", want.payload_len, got.payload_len);
                compare_field("data_byte",   want.data_byte,   got.data_byte);
                compare_field("byte_index",  want.byte_index,  got.byte_index);
                compare_field("has_data",    want.has_data,    got.has_data);
                compare_field("last",        want.last,        got.last);
                compare_field("linked",      want.linked,      got.linked);
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    in_t        s_data;
    logic       m_valid;
    logic       m_ready;
    out_t       m_data;

    frame_tracker tracker;
    int unsigned  cycle_count;
    int unsigned  items_sent;
    bit           steady;      // suppress idling on both sides
    logic [7:0]   cur_head;

    sum_check_frame_receiver DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // Free-running clock, period 10
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: abandon the run if the block hangs or never drains
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: drop ready at random on the falling edge,
    // except through the steady stretch where it stays high throughout
    always @(negedge aclk) begin
        m_ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Check every result transaction against the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
    end

    // Offer one transaction on the input channel and hold it until taken.
    // Idle single cycles first at random; the payload changes only on the
    // falling edge and valid never waits for ready.
    task automatic send_item(input logic op, input logic [7:0] b);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid = 1'b0;
            s_data  = '{opcode: 1'($urandom_range(0, 1)), rx_byte: 8'($urandom_range(0, 255))};
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = '{opcode: op, rx_byte: b};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.accept_item(s_data);
        items_sent++;
    endtask

    // Lower valid once the last transaction has been taken
    task automatic go_quiet();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Send a whole frame: head, length, body, checksum. Corrupt the checksum
    // on request, and optionally plant the head value in the last body byte.
    task automatic send_frame(input int unsigned len, input bit corrupt, input bit plant_head);
        logic [7:0] body [LEN_LIMIT];
        logic [7:0] sum;
        logic [7:0] chk;
        sum = 8'(len);
        for (int unsigned i = 0; i < len; i++) begin
            body[i] = 8'($urandom_range(0, 255));
            if (plant_head && len > 1 && i == len - 1) body[i] = cur_head;
            sum = sum + body[i];
        end
        chk = ~sum + 8'd1;
        if (corrupt) chk = chk + 8'($urandom_range(1, 255));
        send_item(OP_BYTE, cur_head);
        send_item(OP_BYTE, 8'(len));
        for (int unsigned i = 0; i < len; i++) send_item(OP_BYTE, body[i]);
        send_item(OP_BYTE, chk);
    endtask

    task automatic send_bad_length(input logic [7:0] len);
        send_item(OP_BYTE, cur_head);
        send_item(OP_BYTE, len);
    endtask

    task automatic send_release();
        send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
    endtask

    // Write the head register only with the block idle: hold valid low,
    // let every due result drain, then give the parser a quiet settling stretch
    task automatic write_head(input logic [7:0] value);
        go_quiet();
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        tracker.head = value;
        cur_head     = value;
    endtask

    // Random traffic: mostly well-formed frames with random content and
    // sizes, some bad checksums and lengths, releases, and stray bytes
    task automatic run_random(input int unsigned quota);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        target = items_sent + quota;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            end else if (pick < 16) begin
                send_release();
            end else if (pick < 21) begin
                send_bad_length(($urandom_range(0, 1) == 0) ? 8'd0
                                : 8'($urandom_range(LEN_LIMIT + 1, 255)));
            end else begin
                // Keep most frames short so the payload drain stays brief
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, LEN_LIMIT)
                      : $urandom_range(1, 6);
                send_frame(len, $urandom_range(0, 99) < 12, $urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 55) send_release();
            end
        end
    endtask

    initial begin
        tracker     = new();
        cycle_count = 0;
        items_sent  = 0;
        steady      = 1'b0;
        cur_head    = 8'hFF;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'h00;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;

        // Hold reset, then release it on a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under a mid-range head value
        write_head(8'hA5);
        send_release();                 // release with nothing pending
        send_bad_length(8'd0);          // zero length
        send_bad_length(8'(LEN_LIMIT + 1)); // just above the buffer limit
        send_bad_length(8'hFF);
        send_frame(1, 1'b0, 1'b0);      // command only, empty payload
        send_frame(2, 1'b0, 1'b0);      // good but dropped: one still pending
        send_release();
        send_frame(2, 1'b1, 1'b0);      // bad checksum
        send_frame(3, 1'b0, 1'b1);      // head value inside the body

        // Random phases, each under its own head value; the extremes first
        write_head(8'h00);
        send_release();
        send_frame(LEN_LIMIT, 1'b0, 1'b1);  // longest frame, full payload
        run_random(RANDOM_ITEMS / 4);

        // No idling on either side through this stretch
        write_head(8'hFF);
        steady = 1'b1;
        run_random(RANDOM_ITEMS / 4);
        steady = 1'b0;

        write_head(8'($urandom_range(1, 254)));
        run_random(RANDOM_ITEMS / 4);

        write_head(8'h5A);
        run_random(RANDOM_ITEMS / 4);

        // Drain: wait for every due result, then a margin for stragglers
        go_quiet();
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
